// ----- rtl/core/kvt_pkg.sv -----
// kvt_pkg: shared types and constants of the knob volume and tone controller
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package kvt_pkg;

  localparam int NotchWidth   = 30;
  localparam int AttenWidth   = 6;
  localparam int ToneWidth    = 4;
  localparam int LimitWidth   = 3;
  localparam int ByteWidth    = 8;
  localparam int CfgIdxWidth  = 8;
  localparam int CfgDataWidth = 8;

  typedef logic signed [NotchWidth-1:0] notch_t;
  typedef logic        [AttenWidth-1:0] atten_t;
  typedef logic signed [ToneWidth-1:0]  tone_t;
  typedef logic        [LimitWidth-1:0] limit_t;
  typedef logic        [ByteWidth-1:0]  cmd_byte_t;
  typedef logic        [CfgIdxWidth-1:0]  cfg_idx_t;
  typedef logic        [CfgDataWidth-1:0] cfg_data_t;

  // selected channel codes
  typedef enum logic [1:0] {
    CH_VOLUME = 2'd0,
    CH_TREBLE = 2'd1,
    CH_BASS   = 2'd2
  } channel_t;

  // configuration register indexes
  localparam cfg_idx_t REG_VOLUME_FLOOR = cfg_idx_t'(0);
  localparam cfg_idx_t REG_TONE_LIMIT   = cfg_idx_t'(1);

  // pending flag bit positions
  localparam int FLAG_VOLUME = 0;
  localparam int FLAG_TREBLE = 1;
  localparam int FLAG_BASS   = 2;

  // reset values
  localparam atten_t    VOLUME_FLOOR_RESET = atten_t'(60);
  localparam limit_t    TONE_LIMIT_RESET   = limit_t'(7);
  localparam atten_t    ATTEN_RESET        = atten_t'(32);
  localparam notch_t    LAST_NOTCH_RESET   = notch_t'(-999);

  // tone command codes around flat
  localparam cmd_byte_t TREBLE_FLAT_BOOST = 8'h7F;
  localparam cmd_byte_t TREBLE_FIRST_UP   = 8'h7E;
  localparam cmd_byte_t TREBLE_FIRST_DOWN = 8'h76;
  localparam cmd_byte_t BASS_FLAT_BOOST   = 8'h6F;
  localparam cmd_byte_t BASS_FIRST_UP     = 8'h6E;
  localparam cmd_byte_t BASS_FIRST_DOWN   = 8'h66;

  // press-and-release marks
  localparam logic [1:0] MARK_PRESS   = 2'b01;
  localparam logic [1:0] MARK_RELEASE = 2'b10;
  localparam logic [1:0] MARK_BOTH    = 2'b11;

endpackage

`default_nettype wire

// ----- rtl/core/kvt_poll_if.sv -----
// kvt_poll_if: request channel carrying one encoder and button poll
// depends on kvt_pkg
`default_nettype none

interface kvt_poll_if;
  import kvt_pkg::*;

  logic   valid;
  logic   ready;
  notch_t notch_position;
  logic   button_level;

  modport source (output valid, output notch_position, output button_level, input ready);
  modport sink   (input valid, input notch_position, input button_level, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/kvt_result_if.sv -----
// kvt_result_if: request channel carrying one result per poll
// depends on kvt_pkg
`default_nettype none

interface kvt_result_if;
  import kvt_pkg::*;

  logic      valid;
  logic      ready;
  logic      send_valid;
  cmd_byte_t send_byte;
  logic [1:0] selection;
  atten_t    volume_atten_steps;
  tone_t     treble_steps;
  tone_t     bass_steps;

  modport source (output valid, output send_valid, output send_byte, output selection,
                  output volume_atten_steps, output treble_steps, output bass_steps,
                  input ready);
  modport sink   (input valid, input send_valid, input send_byte, input selection,
                  input volume_atten_steps, input treble_steps, input bass_steps,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/kvt_cfg_if.sv -----
// kvt_cfg_if: configuration write channel, register index and write data
// depends on kvt_pkg
`default_nettype none

interface kvt_cfg_if;
  import kvt_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/knob_volume_tone_register_control.sv -----
// knob_volume_tone_register_control: rotary knob volume, treble and bass control
// depends on kvt_pkg, kvt_poll_if, kvt_result_if, kvt_cfg_if
//
// One poll request (encoder notch position and button level) gives exactly one
// result request. Any change of the notch position since the previous poll is a
// single step up or down on the selected channel: volume attenuation in 1.25 dB
// steps, or treble or bass in 2 dB steps, held within the configured limits. A
// completed press and release of the button moves the selection volume, treble,
// bass and round again. Each changed channel raises a pending flag, and at most
// one command byte goes out per poll, volume first, then treble, then bass.
// Timing: a poll passes through an input register and then a result register,
// from which its result is offered. One poll is taken every cycle while results
// are taken, and the state update is the only loop. Configuration writes are
// always taken and must only be made while idle.
`default_nettype none

module knob_volume_tone_register_control (
  input  wire logic     clk,
  input  wire logic     rst,
  kvt_poll_if.sink      poll,
  kvt_result_if.source  result,
  kvt_cfg_if.sink       cfg
);
  import kvt_pkg::*;

  typedef struct packed {
    tone_t     count;
    cmd_byte_t code;
    logic      moved;
  } tone_upd_t;

  // one tone step, ignored past the limit in either direction
  function automatic tone_upd_t tone_step(
    input tone_t     count,
    input cmd_byte_t code,
    input logic      up,
    input limit_t    lim,
    input cmd_byte_t first_up,
    input cmd_byte_t first_down
  );
    tone_upd_t         r;
    logic signed [4:0] cnt5;
    logic signed [4:0] lim5;
    cnt5    = {count[ToneWidth-1], count};
    lim5    = $signed({2'b00, lim});
    r.count = count;
    r.code  = code;
    r.moved = 1'b0;
    if (up) begin
      if (cnt5 < lim5) begin
        if (cnt5 > 5'sd0)      r.code = code - cmd_byte_t'(1);
        else if (cnt5 < 5'sd0) r.code = code + cmd_byte_t'(1);
        else                   r.code = first_up;
        r.count = count + tone_t'(1);
        r.moved = 1'b1;
      end
    end else begin
      if (cnt5 > -lim5) begin
        if (cnt5 > 5'sd0)      r.code = code + cmd_byte_t'(1);
        else if (cnt5 < 5'sd0) r.code = code - cmd_byte_t'(1);
        else                   r.code = first_down;
        r.count = count - tone_t'(1);
        r.moved = 1'b1;
      end
    end
    return r;
  endfunction

  // configuration registers
  atten_t volume_floor;
  limit_t tone_limit;

  // controller state
  channel_t   selected;
  atten_t     atten_count;
  tone_t      treble_count;
  cmd_byte_t  treble_code;
  tone_t      bass_count;
  cmd_byte_t  bass_code;
  logic [2:0] pending;
  notch_t     last_notch;
  logic       prev_button;
  logic [1:0] marks;

  // input register
  logic   in_valid;
  notch_t in_notch;
  logic   in_button;

  // result register
  logic       out_valid;
  logic       out_send_valid;
  cmd_byte_t  out_send_byte;
  channel_t   out_selection;
  atten_t     out_atten;
  tone_t      out_treble;
  tone_t      out_bass;

  logic advance;
  logic take_poll;

  // next values
  channel_t   selected_next;
  atten_t     atten_count_next;
  tone_t      treble_count_next;
  cmd_byte_t  treble_code_next;
  tone_t      bass_count_next;
  cmd_byte_t  bass_code_next;
  logic [2:0] pending_next;
  logic [1:0] marks_next;
  logic       send_next;
  cmd_byte_t  byte_next;
  logic       step_up;
  logic       step_down;
  tone_upd_t  treble_upd;
  tone_upd_t  bass_upd;

  // result stage moves when empty or being taken
  assign advance   = !out_valid || result.ready;
  assign poll.ready = !in_valid || advance;
  assign take_poll = poll.valid && poll.ready;
  assign cfg.ready = 1'b1;

  assign result.valid              = out_valid;
  assign result.send_valid         = out_send_valid;
  assign result.send_byte          = out_send_byte;
  assign result.selection          = out_selection;
  assign result.volume_atten_steps = out_atten;
  assign result.treble_steps       = out_treble;
  assign result.bass_steps         = out_bass;

  always_comb begin
    step_up   = in_notch > last_notch;
    step_down = in_notch < last_notch;

    treble_upd = tone_step(treble_count, treble_code, step_up, tone_limit,
                           TREBLE_FIRST_UP, TREBLE_FIRST_DOWN);
    bass_upd   = tone_step(bass_count, bass_code, step_up, tone_limit,
                           BASS_FIRST_UP, BASS_FIRST_DOWN);

    atten_count_next  = atten_count;
    treble_count_next = treble_count;
    treble_code_next  = treble_code;
    bass_count_next   = bass_count;
    bass_code_next    = bass_code;
    pending_next      = pending;

    // encoder step acts on the selection held before this poll
    if (step_up || step_down) begin
      case (selected)
        CH_VOLUME: begin
          if (step_up && atten_count != '0) begin
            atten_count_next          = atten_count - atten_t'(1);
            pending_next[FLAG_VOLUME] = 1'b1;
          end else if (step_down && atten_count < volume_floor) begin
            atten_count_next          = atten_count + atten_t'(1);
            pending_next[FLAG_VOLUME] = 1'b1;
          end
        end
        CH_TREBLE: begin
          treble_count_next = treble_upd.count;
          treble_code_next  = treble_upd.code;
          if (treble_upd.moved) pending_next[FLAG_TREBLE] = 1'b1;
        end
        CH_BASS: begin
          bass_count_next = bass_upd.count;
          bass_code_next  = bass_upd.code;
          if (bass_upd.moved) pending_next[FLAG_BASS] = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // button edges; a release before a press is remembered too
    marks_next = marks;
    if (in_button != prev_button) begin
      marks_next = marks | (in_button ? MARK_PRESS : MARK_RELEASE);
    end
    selected_next = selected;
    if (marks_next == MARK_BOTH) begin
      case (selected)
        CH_VOLUME: selected_next = CH_TREBLE;
        CH_TREBLE: selected_next = CH_BASS;
        default:   selected_next = CH_VOLUME;
      endcase
      marks_next = '0;
    end

    // at most one byte per poll, volume first
    send_next = 1'b0;
    byte_next = '0;
    if (pending_next[FLAG_VOLUME]) begin
      send_next                 = 1'b1;
      byte_next                 = cmd_byte_t'(atten_count_next);
      pending_next[FLAG_VOLUME] = 1'b0;
    end else if (pending_next[FLAG_TREBLE]) begin
      send_next                 = 1'b1;
      byte_next                 = treble_code_next;
      pending_next[FLAG_TREBLE] = 1'b0;
    end else if (pending_next[FLAG_BASS]) begin
      send_next                 = 1'b1;
      byte_next                 = bass_code_next;
      pending_next[FLAG_BASS]   = 1'b0;
    end
  end

  // configuration writes; other indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      volume_floor <= VOLUME_FLOOR_RESET;
      tone_limit   <= TONE_LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == REG_VOLUME_FLOOR) volume_floor <= cfg.data[AttenWidth-1:0];
      else if (cfg.index == REG_TONE_LIMIT) tone_limit <= cfg.data[LimitWidth-1:0];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (poll.ready) begin
      in_valid <= poll.valid;
    end
    if (take_poll) begin
      in_notch  <= poll.notch_position;
      in_button <= poll.button_level;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      selected     <= CH_VOLUME;
      atten_count  <= ATTEN_RESET;
      treble_count <= '0;
      treble_code  <= TREBLE_FLAT_BOOST;
      bass_count   <= '0;
      bass_code    <= BASS_FLAT_BOOST;
      pending      <= '0;
      last_notch   <= LAST_NOTCH_RESET;
      prev_button  <= 1'b0;
      marks        <= '0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        selected     <= selected_next;
        atten_count  <= atten_count_next;
        treble_count <= treble_count_next;
        treble_code  <= treble_code_next;
        bass_count   <= bass_count_next;
        bass_code    <= bass_code_next;
        pending      <= pending_next;
        last_notch   <= in_notch;
        prev_button  <= in_button;
        marks        <= marks_next;
      end
    end
    if (advance && in_valid) begin
      out_send_valid <= send_next;
      out_send_byte  <= byte_next;
      out_selection  <= selected_next;
      out_atten      <= atten_count_next;
      out_treble     <= treble_count_next;
      out_bass       <= bass_count_next;
    end
  end

endmodule

`default_nettype wire
